// File: hdl/a64_lsd_pkg.sv
// ----------------------------------------------------------------------------
// a64_lsd_pkg
// Shared types and encodings for the AArch64 load/store decoder: result
// kinds, direction and index-mode codes, match patterns, small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package a64_lsd_pkg;

  typedef enum logic [3:0] {
    KIND_NONE     = 4'd0,
    KIND_LITERAL  = 4'd1,
    KIND_PREFETCH = 4'd2,
    KIND_STRUCT   = 4'd3,
    KIND_PAIR     = 4'd4,
    KIND_ATOMIC   = 4'd5,
    KIND_EXCL     = 4'd6,
    KIND_UNSIGNED = 4'd7,
    KIND_REGISTER = 4'd8,
    KIND_UNSCALED = 4'd9
  } kind_t;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_READ  = 2'd1;
  localparam logic [1:0] DIR_WRITE = 2'd2;
  localparam logic [1:0] DIR_RW    = 2'd3;

  localparam logic [1:0] IDX_NONE = 2'd0;
  localparam logic [1:0] IDX_WB   = 2'd1;
  localparam logic [1:0] IDX_POST = 2'd2;

  // mask / match pairs
  localparam logic [31:0] CASP_MASK   = 32'hBFA07C00;
  localparam logic [31:0] CASP_MATCH  = 32'h08207C00;
  localparam logic [31:0] PAIR_MASK   = 32'h3A000000;
  localparam logic [31:0] PAIR_MATCH  = 32'h28000000;
  localparam logic [31:0] UOFF_MASK   = 32'h3B000000;
  localparam logic [31:0] UOFF_MATCH  = 32'h39000000;
  localparam logic [31:0] REGO_MASK   = 32'h3B200C00;
  localparam logic [31:0] REGO_MATCH  = 32'h38200800;
  localparam logic [31:0] AMO_MASK    = 32'h3B200C00;
  localparam logic [31:0] AMO_MATCH   = 32'h38200000;
  localparam logic [31:0] USCL_MASK   = 32'h3B200000;
  localparam logic [31:0] USCL_MATCH  = 32'h38000000;
  localparam logic [31:0] CAS_MASK    = 32'h3FA07C00;
  localparam logic [31:0] CAS_MATCH   = 32'h08A07C00;
  localparam logic [31:0] EXCL_MASK   = 32'h3F000000;
  localparam logic [31:0] EXCL_MATCH  = 32'h08000000;
  localparam logic [31:0] STRC_MASK   = 32'hBE000000;
  localparam logic [31:0] STRC_MATCH  = 32'h0C000000;
  localparam logic [31:0] LDST_MASK   = 32'h0A000000;
  localparam logic [31:0] LDST_MATCH  = 32'h08000000;
  localparam logic [31:0] LIT_MASK    = 32'h3B000000;
  localparam logic [31:0] LIT_MATCH   = 32'h18000000;
  localparam logic [31:0] LITV_MASK   = 32'h3F000000;
  localparam logic [31:0] LITV_MATCH  = 32'h1C000000;
  localparam logic [7:0]  LDRSW_LIT   = 8'h98;
  localparam logic [7:0]  PRFM_LIT    = 8'hD8;

  function automatic logic is_rsv(input logic [4:0] r);
    is_rsv = (r == 5'd16) || (r == 5'd17) || (r == 5'd18) ||
             (r == 5'd28) || (r == 5'd30);
  endfunction

  // total bytes of a SIMD structure transfer
  function automatic logic [7:0] struct_bytes(input logic [31:0] w);
    logic [2:0] regs;
    logic [1:0] scale;
    logic [2:0] elems;
    regs  = 3'd0;
    scale = w[15:14];
    elems = 3'({w[13], w[21]}) + 3'd1;
    if (!w[24]) begin
      case (w[15:12])
        4'd0, 4'd2:  regs = 3'd4;
        4'd4, 4'd6:  regs = 3'd3;
        4'd8, 4'd10: regs = 3'd2;
        4'd7:        regs = 3'd1;
        default:     regs = 3'd0;
      endcase
      struct_bytes = 8'({regs, 3'b000}) << w[30];
    end else begin
      if (scale == 2'd3) begin
        scale = w[11:10];
      end
      struct_bytes = 8'(elems) << scale;
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/a64_load_store_decoder_top.sv
// ----------------------------------------------------------------------------
// a64_load_store_decoder_top
// AArch64 load/store instruction decoder, four-stage pipeline.
//
// Input channel: instr_word with in_valid / in_ready. Output channel: one
// decoded transaction per input (access_kind, register numbers, vector flag,
// byte offset, size, direction, index mode, reserved-register flag) with
// out_valid / out_ready. Words that are not memory accesses come out as
// kind 0 with every other field zero.
// Pipeline: out_valid rises once the word has passed through four
// register stages (input register, class decode, size/offset/direction
// decode, offset shift and output register).
// Throughput: one transaction per cycle while out_ready is high; every stage
// is a register with its own valid bit, so all four can be full at once.
// Stall: when out_ready is low the pipeline fills up and holds; in_ready
// drops only once all four stages are occupied. Nothing is dropped or
// repeated.
// Reset: rst (synchronous) empties all stages; no clearing time.
// ----------------------------------------------------------------------------
`default_nettype none

module a64_load_store_decoder_top (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               in_valid,
  output logic                     in_ready,
  input  wire  logic [31:0]        instr_word,
  output logic                     out_valid,
  input  wire  logic               out_ready,
  output logic [3:0]               access_kind,
  output logic [4:0]               base_reg,
  output logic [4:0]               target_reg,
  output logic [4:0]               target2_reg,
  output logic [4:0]               index_reg,
  output logic                     is_vector,
  output logic signed [20:0]       byte_offset,
  output logic [7:0]               access_bytes,
  output logic [1:0]               direction,
  output logic [1:0]               index_mode,
  output logic                     uses_reserved
);

  import a64_lsd_pkg::*;

  typedef enum logic [3:0] {
    CLS_NONE,
    CLS_LITERAL,
    CLS_STRUCT,
    CLS_PAIR,
    CLS_EXCL,
    CLS_ATOMIC,
    CLS_UNSIGNED,
    CLS_REGISTER,
    CLS_UNSCALED
  } cls_t;

  // handshake chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdyo;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: input word
  logic [31:0] w1;

  // stage 1 -> 2: class decode
  logic  lit1, pf1, casp1;
  cls_t  cls1_next;
  kind_t kind1_next;

  assign lit1 = ((w1 & LIT_MASK) == LIT_MATCH) || (w1[31:24] == LDRSW_LIT) ||
                ((w1 & LITV_MASK) == LITV_MATCH) || (w1[31:24] == PRFM_LIT);
  assign pf1  = !w1[26] && (w1[31:30] == 2'b11) && (w1[23:22] == 2'b10);
  assign casp1 = (w1 & CASP_MASK) == CASP_MATCH;

  always_comb begin
    cls1_next  = CLS_NONE;
    kind1_next = KIND_NONE;
    if (lit1) begin
      cls1_next  = CLS_LITERAL;
      kind1_next = (w1[31:24] == PRFM_LIT) ? KIND_PREFETCH : KIND_LITERAL;
    end else if ((w1 & LDST_MASK) != LDST_MATCH) begin
      cls1_next  = CLS_NONE;
      kind1_next = KIND_NONE;
    end else if ((w1 & STRC_MASK) == STRC_MATCH) begin
      cls1_next  = CLS_STRUCT;
      kind1_next = KIND_STRUCT;
    end else if ((w1 & PAIR_MASK) == PAIR_MATCH) begin
      cls1_next  = CLS_PAIR;
      kind1_next = KIND_PAIR;
    end else if ((w1 & EXCL_MASK) == EXCL_MATCH) begin
      cls1_next  = CLS_EXCL;
      kind1_next = (casp1 || w1[23]) ? KIND_ATOMIC : KIND_EXCL;
    end else if ((w1 & AMO_MASK) == AMO_MATCH) begin
      cls1_next  = CLS_ATOMIC;
      kind1_next = KIND_ATOMIC;
    end else if ((w1 & UOFF_MASK) == UOFF_MATCH) begin
      cls1_next  = CLS_UNSIGNED;
      kind1_next = pf1 ? KIND_PREFETCH : KIND_UNSIGNED;
    end else if ((w1 & REGO_MASK) == REGO_MATCH) begin
      cls1_next  = CLS_REGISTER;
      kind1_next = pf1 ? KIND_PREFETCH : KIND_REGISTER;
    end else if ((w1 & USCL_MASK) == USCL_MATCH) begin
      cls1_next  = CLS_UNSCALED;
      kind1_next = pf1 ? KIND_PREFETCH : KIND_UNSCALED;
    end
  end

  // stage 2
  logic [31:0] w2;
  cls_t        cls2;
  kind_t       kind2;

  logic        vec2, casp2, post2;
  logic [1:0]  size2;
  logic [2:0]  lb2;
  logic [7:0]  bytes2;
  logic [20:0] imm2;
  logic [2:0]  sh2;
  logic [1:0]  mode2;
  logic [1:0]  dir2;
  logic        rd2;
  logic [4:0]  base2;
  logic        rsv2;

  assign vec2  = w2[26];
  assign size2 = w2[31:30];
  assign casp2 = (w2 & CASP_MASK) == CASP_MATCH;

  // log2 of bytes moved for the non-literal, non-structure classes
  always_comb begin
    if (casp2) begin
      lb2 = w2[30] ? 3'd4 : 3'd3;
    end else if (cls2 == CLS_PAIR) begin
      lb2 = vec2 ? (3'(size2) + 3'd3) : ((size2 == 2'd2) ? 3'd4 : 3'd3);
    end else begin
      lb2 = vec2 ? {w2[23], size2} : 3'(size2);
      if (((w2 & EXCL_MASK) == EXCL_MATCH) && !w2[23] && w2[21]) begin
        lb2 = lb2 + 3'd1;
      end
    end
  end

  always_comb begin
    case (cls2)
      CLS_NONE: begin
        bytes2 = 8'd0;
      end
      CLS_LITERAL: begin
        if (kind2 == KIND_PREFETCH) begin
          bytes2 = 8'd0;
        end else if (w2[31:24] == LDRSW_LIT) begin
          bytes2 = 8'd4;
        end else if ((w2 & LITV_MASK) == LITV_MATCH) begin
          bytes2 = 8'd4 << size2;
        end else begin
          bytes2 = w2[30] ? 8'd8 : 8'd4;
        end
      end
      CLS_STRUCT: begin
        bytes2 = struct_bytes(w2);
      end
      default: begin
        bytes2 = (kind2 == KIND_PREFETCH) ? 8'd0 : (8'd1 << lb2);
      end
    endcase
  end

  always_comb begin
    imm2  = '0;
    sh2   = '0;
    mode2 = IDX_NONE;
    post2 = 1'b0;
    case (cls2)
      CLS_LITERAL: begin
        imm2 = {{2{w2[23]}}, w2[23:5]};
        sh2  = 3'd2;
      end
      CLS_STRUCT: begin
        mode2 = w2[23] ? IDX_WB : IDX_NONE;
      end
      CLS_PAIR: begin
        post2 = (w2[24:23] == 2'b01);
        imm2  = post2 ? '0 : {{14{w2[21]}}, w2[21:15]};
        sh2   = lb2 - 3'd1;
        mode2 = post2 ? IDX_POST : ((w2[24:23] == 2'b11) ? IDX_WB : IDX_NONE);
      end
      CLS_UNSIGNED: begin
        imm2 = {9'd0, w2[21:10]};
        sh2  = lb2;
      end
      CLS_UNSCALED: begin
        post2 = (w2[11:10] == 2'b01);
        imm2  = post2 ? '0 : {{12{w2[20]}}, w2[20:12]};
        mode2 = post2 ? IDX_POST : ((w2[11:10] == 2'b11) ? IDX_WB : IDX_NONE);
      end
      default: begin
        imm2 = '0;
      end
    endcase
  end

  always_comb begin
    case (kind2)
      KIND_LITERAL: rd2 = 1'b1;
      KIND_UNSIGNED, KIND_REGISTER, KIND_UNSCALED:
        rd2 = vec2 ? w2[22] : (w2[23:22] != 2'b00);
      default: rd2 = w2[22];
    endcase
    if ((kind2 == KIND_NONE) || (kind2 == KIND_PREFETCH)) begin
      dir2 = DIR_NONE;
    end else if (((w2 & AMO_MASK) == AMO_MATCH) || casp2 ||
                 ((w2 & CAS_MASK) == CAS_MATCH)) begin
      dir2 = DIR_RW;
    end else begin
      dir2 = rd2 ? DIR_READ : DIR_WRITE;
    end
  end

  assign base2 = (cls2 == CLS_LITERAL) ? 5'd31 : w2[9:5];

  assign rsv2 = is_rsv(base2) ||
                (!vec2 && is_rsv(w2[4:0])) ||
                ((kind2 == KIND_PAIR) && !vec2 && is_rsv(w2[14:10])) ||
                (((kind2 == KIND_REGISTER) || (kind2 == KIND_STRUCT && w2[23]) ||
                  (kind2 == KIND_ATOMIC)) && is_rsv(w2[20:16]));

  // stage 3
  kind_t       kind3;
  logic [4:0]  base3, tgt3, tgt23, idx3;
  logic        vec3;
  logic [20:0] imm3;
  logic [2:0]  sh3;
  logic [7:0]  bytes3;
  logic [1:0]  dir3, mode3;
  logic        rsv3;
  logic        none3;

  assign none3 = (kind3 == KIND_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdyo) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      w1 <= instr_word;
    end
    if (rdy2) begin
      w2    <= w1;
      cls2  <= cls1_next;
      kind2 <= kind1_next;
    end
    if (rdy3) begin
      kind3  <= kind2;
      base3  <= base2;
      tgt3   <= w2[4:0];
      tgt23  <= w2[14:10];
      idx3   <= w2[20:16];
      vec3   <= vec2;
      imm3   <= imm2;
      sh3    <= sh2;
      bytes3 <= bytes2;
      dir3   <= dir2;
      mode3  <= mode2;
      rsv3   <= rsv2;
    end
    if (rdyo) begin
      access_kind   <= kind3;
      base_reg      <= none3 ? 5'd0 : base3;
      target_reg    <= none3 ? 5'd0 : tgt3;
      target2_reg   <= none3 ? 5'd0 : tgt23;
      index_reg     <= none3 ? 5'd0 : idx3;
      is_vector     <= none3 ? 1'b0 : vec3;
      byte_offset   <= none3 ? 21'sd0 : $signed(imm3 << sh3);
      access_bytes  <= none3 ? 8'd0 : bytes3;
      direction     <= none3 ? DIR_NONE : dir3;
      index_mode    <= none3 ? IDX_NONE : mode3;
      uses_reserved <= none3 ? 1'b0 : rsv3;
    end
  end

endmodule

`default_nettype wire

// File: test/tb_a64_load_store_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_a64_load_store_decoder_top
// Self-checking bench for the load/store decoder. Directed words cover every
// access class and the offset extremes. They are followed by random words,
// mostly built on each class pattern with random fields and reserved register
// numbers, plus some raw noise. An in-bench decoder predicts every
// transaction, and each output field is compared in order. Both handshakes
// see random stalls. A long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------

module tb_a64_load_store_decoder_top;

  import a64_lsd_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 200;

  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic [4:0]  base;
    logic [4:0]  target;
    logic [4:0]  target2;
    logic [4:0]  index;
    logic        vec;
    logic [20:0] offset;
    logic [7:0]  nbytes;
    logic [1:0]  dir;
    logic [1:0]  mode;
    logic        rsv;
  } decode_t;

  class decode_scoreboard;
    decode_t pending_decodes[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    function bit reserved_reg(logic [4:0] r);
      return r inside {5'd16, 5'd17, 5'd18, 5'd28, 5'd30};
    endfunction

    function bit casp_form(logic [31:0] w);
      return (w & 32'hBFA07C00) == 32'h08207C00;
    endfunction

    function bit pair_form(logic [31:0] w);
      return (w & 32'h3A000000) == 32'h28000000;
    endfunction

    function logic [31:0] widen_signed(logic [31:0] v, int bits);
      logic [31:0] shifted;
      shifted = v << (32 - bits);
      return $signed(shifted) >>> (32 - bits);
    endfunction

    function int lowest_set(logic [31:0] b);
      int n;
      n = 0;
      while (n < 8 && !b[0]) begin
        b = b >> 1;
        n++;
      end
      return n;
    endfunction

    function logic [31:0] transfer_bytes(logic [31:0] w);
      logic [31:0] b;
      if (casp_form(w)) return w[30] ? 32'd16 : 32'd8;
      if (pair_form(w)) begin
        b = w[26] ? (32'd4 << w[31:30]) : ((w[31:30] == 2'd2) ? 32'd8 : 32'd4);
      end else if (!w[26]) begin
        b = 32'd1 << w[31:30];
      end else begin
        b = 32'd1 << {w[23], w[31:30]};
      end
      if ((w & 32'h3F000000) == 32'h08000000 && !w[23] && w[21]) b = b * 2;
      return pair_form(w) ? b * 2 : b;
    endfunction

    function bit prefetch_form(logic [31:0] w);
      if (w[31:24] == 8'hD8) return 1'b1;
      if (w[26] || w[31:30] != 2'b11 || w[23:22] != 2'b10) return 1'b0;
      return (w & 32'h3B000000) == 32'h39000000 ||
             (w & 32'h3B200000) == 32'h38000000 ||
             (w & 32'h3B200C00) == 32'h38200800;
    endfunction

    function logic [31:0] struct_transfer_bytes(logic [31:0] w);
      logic [31:0] regs;
      logic [31:0] elems;
      logic [1:0]  scale;
      if (!w[24]) begin
        case (w[15:12])
          4'd0, 4'd2: regs = 4;
          4'd4, 4'd6: regs = 3;
          4'd8, 4'd10: regs = 2;
          4'd7: regs = 1;
          default: regs = 0;
        endcase
        return regs * (w[30] ? 32'd16 : 32'd8);
      end
      scale = w[15:14];
      elems = 32'({w[13], w[21]}) + 32'd1;
      if (scale == 2'd3) scale = w[11:10];
      return elems << scale;
    endfunction

    function decode_t decode_word(logic [31:0] w);
      decode_t     d;
      kind_t       k;
      logic [31:0] off;
      logic [31:0] nbytes;
      logic [4:0]  base;
      logic [1:0]  mode;
      bit          wb;
      bit          post;
      bit          rd;
      d = '0;
      d.word = w;
      off = 0;
      nbytes = 0;
      wb = 1'b0;
      post = 1'b0;
      base = w[9:5];
      if ((w & 32'h3B000000) == 32'h18000000 || w[31:24] == 8'h98 ||
          (w & 32'h3F000000) == 32'h1C000000 || w[31:24] == 8'hD8) begin
        k = prefetch_form(w) ? KIND_PREFETCH : KIND_LITERAL;
        off = widen_signed(w >> 5, 19) << 2;
        base = 5'd31;
      end else if ((w & 32'h0A000000) != 32'h08000000) begin
        return d;
      end else if ((w & 32'hBE000000) == 32'h0C000000) begin
        k = KIND_STRUCT;
        wb = w[23];
        nbytes = struct_transfer_bytes(w);
      end else if (pair_form(w)) begin
        k = KIND_PAIR;
        mode = w[24:23];
        post = mode == 2'd1;
        wb = mode == 2'd1 || mode == 2'd3;
        off = post ? 32'd0 : widen_signed(w >> 15, 7) * (transfer_bytes(w) / 2);
      end else if ((w & 32'h3F000000) == 32'h08000000) begin
        k = (casp_form(w) || w[23]) ? KIND_ATOMIC : KIND_EXCL;
      end else if ((w & 32'h3B200C00) == 32'h38200000) begin
        k = KIND_ATOMIC;
      end else if ((w & 32'h3B000000) == 32'h39000000) begin
        k = prefetch_form(w) ? KIND_PREFETCH : KIND_UNSIGNED;
        off = {20'd0, w[21:10]} << lowest_set(transfer_bytes(w));
      end else if ((w & 32'h3B200C00) == 32'h38200800) begin
        k = prefetch_form(w) ? KIND_PREFETCH : KIND_REGISTER;
      end else if ((w & 32'h3B200000) == 32'h38000000) begin
        k = prefetch_form(w) ? KIND_PREFETCH : KIND_UNSCALED;
        mode = w[11:10];
        post = mode == 2'd1;
        wb = mode == 2'd1 || mode == 2'd3;
        off = post ? 32'd0 : widen_signed(w >> 12, 9);
      end else begin
        return d;
      end

      if (k == KIND_PREFETCH) begin
        nbytes = 0;
      end else if (k == KIND_LITERAL) begin
        if (w[31:24] == 8'h98) nbytes = 4;
        else if ((w & 32'h3F000000) == 32'h1C000000) nbytes = 32'd4 << w[31:30];
        else nbytes = w[30] ? 32'd8 : 32'd4;
      end else if (k != KIND_STRUCT) begin
        nbytes = transfer_bytes(w);
      end

      d.dir = DIR_NONE;
      if (k != KIND_PREFETCH) begin
        if (k == KIND_LITERAL) rd = 1'b1;
        else if (k == KIND_UNSIGNED || k == KIND_REGISTER || k == KIND_UNSCALED)
          rd = w[26] ? w[22] : (w[23:22] != 2'd0);
        else rd = w[22];
        d.dir = rd ? DIR_READ : DIR_WRITE;
        if ((w & 32'h3B200C00) == 32'h38200000 || casp_form(w) ||
            (w & 32'h3FA07C00) == 32'h08A07C00) d.dir = DIR_RW;
      end

      d.kind = k;
      d.base = base;
      d.target = w[4:0];
      d.target2 = w[14:10];
      d.index = w[20:16];
      d.vec = w[26];
      d.offset = off[20:0];
      d.nbytes = nbytes[7:0];
      d.mode = post ? IDX_POST : (wb ? IDX_WB : IDX_NONE);
      d.rsv = reserved_reg(base) ||
              (!w[26] && reserved_reg(w[4:0])) ||
              (k == KIND_PAIR && !w[26] && reserved_reg(w[14:10])) ||
              ((k == KIND_REGISTER || (k == KIND_STRUCT && wb && w[20:16] != 5'd31)) &&
               reserved_reg(w[20:16])) ||
              (k == KIND_ATOMIC && reserved_reg(w[20:16]));
      return d;
    endfunction

    function void note_word(logic [31:0] w);
      pending_decodes.push_back(decode_word(w));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got,
                              logic [31:0] w);
      if (want !== got) begin
        errors++;
        $display("%0t: word %h %s expected %0h got %0h", $time, w, name, want, got);
      end
    endfunction

    function void check_result(decode_t got);
      decode_t want;
      if (pending_decodes.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none got kind %0h",
                 $time, got.kind);
        return;
      end
      want = pending_decodes.pop_front();
      check_field("access_kind", 32'(want.kind), 32'(got.kind), want.word);
      check_field("base_reg", 32'(want.base), 32'(got.base), want.word);
      check_field("target_reg", 32'(want.target), 32'(got.target), want.word);
      check_field("target2_reg", 32'(want.target2), 32'(got.target2), want.word);
      check_field("index_reg", 32'(want.index), 32'(got.index), want.word);
      check_field("is_vector", 32'(want.vec), 32'(got.vec), want.word);
      check_field("byte_offset", 32'(want.offset), 32'(got.offset), want.word);
      check_field("access_bytes", 32'(want.nbytes), 32'(got.nbytes), want.word);
      check_field("direction", 32'(want.dir), 32'(got.dir), want.word);
      check_field("index_mode", 32'(want.mode), 32'(got.mode), want.word);
      check_field("uses_reserved", 32'(want.rsv), 32'(got.rsv), want.word);
    endfunction

    function void check_leftovers();
      if (pending_decodes.size() != 0) begin
        errors++;
        $display("%0t: %0d transactions expected but never seen, first word %h",
                 $time, pending_decodes.size(), pending_decodes[0].word);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        instr_word;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         access_kind;
  logic [4:0]         base_reg;
  logic [4:0]         target_reg;
  logic [4:0]         target2_reg;
  logic [4:0]         index_reg;
  logic               is_vector;
  logic signed [20:0] byte_offset;
  logic [7:0]         access_bytes;
  logic [1:0]         direction;
  logic [1:0]         index_mode;
  logic               uses_reserved;

  decode_scoreboard sb;
  int  words_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  hold_request = 1'b0;
  bit  sender_gaps = 1'b1;
  bit  sink_stalls = 1'b1;

  a64_load_store_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .instr_word    (instr_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .access_kind   (access_kind),
    .base_reg      (base_reg),
    .target_reg    (target_reg),
    .target2_reg   (target2_reg),
    .index_reg     (index_reg),
    .is_vector     (is_vector),
    .byte_offset   (byte_offset),
    .access_bytes  (access_bytes),
    .direction     (direction),
    .index_mode    (index_mode),
    .uses_reserved (uses_reserved)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [4:0] special_reg();
    case ($urandom_range(0, 5))
      0: return 5'd16;
      1: return 5'd17;
      2: return 5'd18;
      3: return 5'd28;
      4: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  // class pattern with random fill, occasionally raw noise
  function automatic logic [31:0] random_word();
    logic [31:0] mask;
    logic [31:0] match;
    logic [31:0] w;
    case ($urandom_range(0, 18))
      0: begin mask = 32'h3B000000; match = 32'h18000000; end
      1: begin mask = 32'hFF000000; match = 32'h98000000; end
      2: begin mask = 32'h3F000000; match = 32'h1C000000; end
      3: begin mask = 32'hFF000000; match = 32'hD8000000; end
      4: begin mask = 32'hBE000000; match = 32'h0C000000; end
      5: begin mask = 32'h3A000000; match = 32'h28000000; end
      6: begin mask = 32'h3F000000; match = 32'h08000000; end
      7: begin mask = 32'hBFA07C00; match = 32'h08207C00; end
      8: begin mask = 32'h3FA07C00; match = 32'h08A07C00; end
      9: begin mask = 32'h3B200C00; match = 32'h38200000; end
      10: begin mask = 32'h3B000000; match = 32'h39000000; end
      11: begin mask = 32'hFFC00000; match = 32'hF9800000; end
      12: begin mask = 32'h3B200C00; match = 32'h38200800; end
      13: begin mask = 32'h3B200000; match = 32'h38000000; end
      14: begin mask = 32'hFFE00000; match = 32'hF8800000; end
      default: begin mask = 32'h0; match = 32'h0; end
    endcase
    w = ($urandom & ~mask) | match;
    if ($urandom_range(0, 3) == 0) w[9:5] = special_reg();
    if ($urandom_range(0, 3) == 0) w[4:0] = special_reg();
    if ($urandom_range(0, 3) == 0) w[14:10] = special_reg();
    if ($urandom_range(0, 3) == 0) w[20:16] = special_reg();
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w);
    in_valid <= 1'b1;
    instr_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    int n;
    n = sender_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      send_word(random_word());
      pause_sender();
    end
  endtask

  task automatic run_directed();
    logic [31:0] words [26];
    words = '{32'h00000000, 32'hFFFFFFFF, 32'h187FFFE0, 32'h58FFFFE1, 32'h98800010,
              32'h9C000000, 32'hD8000000, 32'h4C407000, 32'h4CDF2000, 32'h0DD08600,
              32'h4DE0E000, 32'h29000000, 32'hA9FFFBFD, 32'h28C00000, 32'hAD7FFFFF,
              32'hC85F7C00, 32'h48207C00, 32'hC8A07C00, 32'hF8200000, 32'hF97FFFFF,
              32'hF9800000, 32'h3DFFFFFF, 32'hF8606BDE, 32'hF8400C00, 32'hF85FF000,
              32'h38000800};
    foreach (words[i]) begin
      send_word(words[i]);
      pause_sender();
    end
  endtask

  always @(posedge clk) begin : monitor
    decode_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(instr_word);
      if (out_valid && out_ready) begin
        got = '0;
        got.kind = kind_t'(access_kind);
        got.base = base_reg;
        got.target = target_reg;
        got.target2 = target2_reg;
        got.index = index_reg;
        got.vec = is_vector;
        got.offset = byte_offset;
        got.nbytes = access_bytes;
        got.dir = direction;
        got.mode = index_mode;
        got.rsv = uses_reserved;
        sb.check_result(got);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL a64_load_store_decoder_top");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 20) stall_left = gap_len();
      end
      @(posedge clk);
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    instr_word = 32'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(400);

    // output held off while input keeps coming
    hold_request = 1'b1;
    sender_gaps = 1'b0;
    run_random(40);
    drain();

    sink_stalls = 1'b0;
    run_random(250);

    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    run_random(300);

    drain();
    repeat (8) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("PASS a64_load_store_decoder_top");
    end else begin
      $display("FAIL a64_load_store_decoder_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/a64_lsd_pkg.sv
hdl/a64_load_store_decoder_top.sv
test/tb_a64_load_store_decoder_top.sv
